// ===== rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and constants for the melody tone sequencer
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int MAX_NOTES_DEF = 256;
  localparam int CLOCK_HZ_DEF  = 32000000;

  localparam int WHOLE_NOTE_RESET = (60000 * 4) / 280;
  localparam int TONE_DIV_SHIFT   = 5;
  localparam int PERIOD_MAX       = 255;
  localparam int PERIOD_MIN       = 1;

  localparam int FREQ_W    = 13;
  localparam int LEN_W     = 8;
  localparam int ENTRY_W   = FREQ_W + LEN_W + 1;
  localparam int WHOLE_W   = 16;
  localparam int COUNT_W   = 9;
  localparam int MS_W      = 17;
  localparam int PER_DIV_W = FREQ_W + TONE_DIV_SHIFT;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SWITCH = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  localparam logic [1:0] CFG_WHOLE_NOTE   = 2'd0;
  localparam logic [1:0] CFG_FIRST_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SECOND_COUNT = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              load_song;
    logic [7:0]        load_index;
    logic [12:0]       load_freq;
    logic signed [7:0] load_length;
  } cmd_t;

  typedef struct packed {
    logic       note_started;
    logic       tone_on;
    logic [7:0] period_count;
    logic [9:0] duty_count;
    logic [7:0] note_number;
    logic       song_playing;
  } result_t;

endpackage

// ===== rtl/melody_tone_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// melody_tone_sequencer_top
// plays two stored melodies from a note memory as tone period and duty beats
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         cmd    (mts_pkg::cmd_t)
//  result    done (1-cycle pulse) result (mts_pkg::result_t)
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  load, switch and non-final tick beats: result in the cycle after accept,
//    next beat may follow at once
//  note fetch: memory read, then one bit-serial pass, shared by period and
//    duration, of clog2(CLOCK_HZ+1) steps (25 at 32 MHz); busy meanwhile
//  rst is synchronous; the note memory is not cleared
//  results cannot be stalled; cfg_ready is always high
// ----------------------------------------------------------------------------
module melody_tone_sequencer_top #(
  parameter int MAX_NOTES = mts_pkg::MAX_NOTES_DEF,
  parameter int CLOCK_HZ  = mts_pkg::CLOCK_HZ_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  mts_pkg::cmd_t                   cmd,
  output logic                            done,
  output mts_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [mts_pkg::WHOLE_W-1:0]     cfg_data
);

  localparam int DEPTH = 2 * MAX_NOTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(MAX_NOTES + 1);
  localparam int CW    = $clog2(CLOCK_HZ + 1);
  localparam int SCW   = $clog2(CW);
  localparam int DW    = mts_pkg::WHOLE_W;
  localparam int PDW   = mts_pkg::PER_DIV_W;
  localparam int LW    = mts_pkg::LEN_W;
  localparam logic [CW-1:0] CLK_DVD = CW'(CLOCK_HZ);

  logic [mts_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [mts_pkg::ENTRY_W-1:0] rd_data;
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [mts_pkg::ENTRY_W-1:0] wr_data;

  mts_pkg::state_t state, state_next;

  logic [DW-1:0]                 whole_ms, whole_ms_next;
  logic [mts_pkg::COUNT_W-1:0]   first_cnt, first_cnt_next;
  logic [mts_pkg::COUNT_W-1:0]   second_cnt, second_cnt_next;
  logic                          song, song_next;
  logic [PW-1:0]                 pos, pos_next;
  logic [mts_pkg::MS_W-1:0]      elapsed, elapsed_next;
  logic [mts_pkg::MS_W-1:0]      note_len, note_len_next;
  logic [7:0]                    num, num_next;
  logic                          tone, tone_next;
  logic                          dotted, dotted_next;
  logic [PDW-1:0]                per_div, per_div_next;
  logic [PDW-1:0]                per_rem, per_rem_next;
  logic [CW-1:0]                 per_dvd, per_dvd_next;
  logic [LW-1:0]                 dur_div, dur_div_next;
  logic [LW-1:0]                 dur_rem, dur_rem_next;
  logic [DW-1:0]                 dur_dvd, dur_dvd_next;
  logic [SCW-1:0]                cnt, cnt_next;
  logic                          done_next;
  mts_pkg::result_t              res_next;

  logic [mts_pkg::COUNT_W-1:0]   cnt_raw, cnt_lim;
  logic [PW-1:0]                 pos_w;
  logic [PDW:0]                  per_sh;
  logic [LW:0]                   dur_sh;
  logic [mts_pkg::LEN_W-1:0]     len_raw;
  logic [7:0]                    period;
  logic [mts_pkg::MS_W-1:0]      dur;

  assign busy      = (state != mts_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // note memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mts_pkg::S_IDLE;
      whole_ms   <= DW'(mts_pkg::WHOLE_NOTE_RESET);
      first_cnt  <= '0;
      second_cnt <= '0;
      song       <= 1'b0;
      pos        <= '0;
      elapsed    <= '0;
      note_len   <= mts_pkg::MS_W'(mts_pkg::WHOLE_NOTE_RESET / 4);
      done       <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      whole_ms   <= whole_ms_next;
      first_cnt  <= first_cnt_next;
      second_cnt <= second_cnt_next;
      song       <= song_next;
      pos        <= pos_next;
      elapsed    <= elapsed_next;
      note_len   <= note_len_next;
      done       <= done_next;
      cnt        <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    result  <= res_next;
    num     <= num_next;
    tone    <= tone_next;
    dotted  <= dotted_next;
    per_div <= per_div_next;
    per_rem <= per_rem_next;
    per_dvd <= per_dvd_next;
    dur_div <= dur_div_next;
    dur_rem <= dur_rem_next;
    dur_dvd <= dur_dvd_next;
  end

  always_comb begin
    state_next      = state;
    whole_ms_next   = whole_ms;
    first_cnt_next  = first_cnt;
    second_cnt_next = second_cnt;
    song_next       = song;
    pos_next        = pos;
    elapsed_next    = elapsed;
    note_len_next   = note_len;
    num_next        = num;
    tone_next       = tone;
    dotted_next     = dotted;
    per_div_next    = per_div;
    per_rem_next    = per_rem;
    per_dvd_next    = per_dvd;
    dur_div_next    = dur_div;
    dur_rem_next    = dur_rem;
    dur_dvd_next    = dur_dvd;
    cnt_next        = cnt;
    done_next       = 1'b0;
    res_next        = result;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = {cmd.load_length, cmd.load_freq};
    cnt_raw         = song ? second_cnt : first_cnt;
    cnt_lim         = (32'(cnt_raw) > MAX_NOTES) ? mts_pkg::COUNT_W'(MAX_NOTES) : cnt_raw;
    pos_w           = ((32'(pos) >= 32'(cnt_lim)) || (32'(pos) >= MAX_NOTES)) ? '0 : pos;
    per_sh          = {per_rem, per_dvd[CW-1]};
    dur_sh          = {dur_rem, dur_dvd[DW-1]};
    len_raw         = rd_data[mts_pkg::ENTRY_W-2 -: mts_pkg::LEN_W];
    period          = 8'(mts_pkg::PERIOD_MIN);
    dur             = '0;

    // register writes
    if (cfg_valid) begin
      unique case (cfg_index)
        mts_pkg::CFG_WHOLE_NOTE:   whole_ms_next   = cfg_data;
        mts_pkg::CFG_FIRST_COUNT:  first_cnt_next  = mts_pkg::COUNT_W'(cfg_data);
        mts_pkg::CFG_SECOND_COUNT: second_cnt_next = mts_pkg::COUNT_W'(cfg_data);
        default: ;
      endcase
    end

    unique case (state)
      mts_pkg::S_IDLE: begin
        if (start) begin
          res_next              = '0;
          res_next.song_playing = song;
          unique case (cmd.req_type)
            mts_pkg::REQ_TICK: begin
              if (elapsed < note_len) begin
                elapsed_next = elapsed + 1'b1;
                done_next    = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = song ? AW'(MAX_NOTES) + AW'(pos_w) : AW'(pos_w);
                num_next   = 8'(pos_w);
                pos_next   = PW'(pos_w + 1'b1);
                state_next = mts_pkg::S_READ;
              end
            end
            mts_pkg::REQ_SWITCH: begin
              song_next             = ~song;
              pos_next              = '0;
              elapsed_next          = '0;
              res_next.song_playing = ~song;
              done_next             = 1'b1;
            end
            mts_pkg::REQ_LOAD: begin
              if (32'(cmd.load_index) < MAX_NOTES) begin
                wr_en   = 1'b1;
                wr_addr = cmd.load_song ? AW'(MAX_NOTES) + AW'(cmd.load_index)
                                        : AW'(cmd.load_index);
              end
              done_next = 1'b1;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      mts_pkg::S_READ: begin
        tone_next    = (rd_data[mts_pkg::FREQ_W-1:0] != '0);
        per_div_next = {rd_data[mts_pkg::FREQ_W-1:0], mts_pkg::TONE_DIV_SHIFT'(0)};
        per_rem_next = '0;
        per_dvd_next = CLK_DVD;
        dotted_next  = len_raw[LW-1];
        if (len_raw[LW-1]) begin
          dur_div_next = LW'(-len_raw);
        end else if (len_raw > LW'(1)) begin
          dur_div_next = len_raw;
        end else begin
          dur_div_next = LW'(1);
        end
        dur_rem_next = '0;
        dur_dvd_next = whole_ms;
        cnt_next     = '0;
        state_next   = mts_pkg::S_DIV;
      end
      mts_pkg::S_DIV: begin
        // one quotient bit a cycle, quotient shifts into the dividend register
        if (per_sh >= {1'b0, per_div}) begin
          per_rem_next = PDW'(per_sh - {1'b0, per_div});
          per_dvd_next = {per_dvd[CW-2:0], 1'b1};
        end else begin
          per_rem_next = PDW'(per_sh);
          per_dvd_next = {per_dvd[CW-2:0], 1'b0};
        end
        if (32'(cnt) < DW) begin
          if (dur_sh >= {1'b0, dur_div}) begin
            dur_rem_next = LW'(dur_sh - {1'b0, dur_div});
            dur_dvd_next = {dur_dvd[DW-2:0], 1'b1};
          end else begin
            dur_rem_next = LW'(dur_sh);
            dur_dvd_next = {dur_dvd[DW-2:0], 1'b0};
          end
        end
        cnt_next = SCW'(cnt + 1'b1);
        if (32'(cnt) == CW - 1) begin
          state_next = mts_pkg::S_FINISH;
        end
      end
      mts_pkg::S_FINISH: begin
        if (per_dvd <= CW'(2)) begin
          period = 8'(mts_pkg::PERIOD_MIN);
        end else if (per_dvd > CW'(mts_pkg::PERIOD_MAX)) begin
          period = 8'(mts_pkg::PERIOD_MAX);
        end else begin
          period = 8'(per_dvd - 1'b1);
        end
        dur = dotted ? mts_pkg::MS_W'(dur_dvd) + mts_pkg::MS_W'(dur_dvd >> 1)
                     : mts_pkg::MS_W'(dur_dvd);
        res_next              = '0;
        res_next.note_started = 1'b1;
        res_next.note_number  = num;
        res_next.song_playing = song;
        if (tone) begin
          res_next.tone_on      = 1'b1;
          res_next.period_count = period;
          res_next.duty_count   = 10'((10'(period) + 10'd1) << 1);
        end
        note_len_next = dur;
        elapsed_next  = '0;
        done_next     = 1'b1;
        state_next    = mts_pkg::S_IDLE;
      end
      default: state_next = mts_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker
// port-level checks for the melody tone sequencer, bound to the top level
// ----------------------------------------------------------------------------
module mts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input mts_pkg::cmd_t               cmd,
  input logic                        done,
  input mts_pkg::result_t            result,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [1:0]                  cfg_index,
  input logic [mts_pkg::WHOLE_W-1:0] cfg_data
);

  // load and switch beats answer in the next cycle
  a_quick_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.req_type != mts_pkg::REQ_TICK) |=> done)
    else $error("no result after a load or switch beat");

  // no result while a note fetch is in flight
  a_busy_quiet: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result while busy");

  a_tone_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.tone_on) |->
      (result.note_started && result.period_count != 8'd0 &&
       result.duty_count == 10'((10'(result.period_count) + 10'd1) << 1)))
    else $error("tone fields inconsistent");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !result.note_started) |->
      (!result.tone_on && result.period_count == 8'd0 &&
       result.duty_count == 10'd0 && result.note_number == 8'd0))
    else $error("fields set without a note start");

  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block active after reset");

endmodule

bind melody_tone_sequencer_top mts_checker u_mts_checker (.*);
